[rtl/ntp_pkg.sv]
package ntp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_PAIRS = 8;
  localparam int HW = 50;

  localparam logic [31:0] P_CAP   = 32'h2000_0000;
  localparam logic [31:0] Q_CAP   = 32'h7FFF_FFFF;
  localparam logic [31:0] ONE_CAP = 32'h0001_0000;
  localparam logic [63:0] AREA_EPS = (64'd1 << (2 * FRAC_BITS)) / 64'd100000;
  localparam logic signed [31:0] DEPTH_MAX = 32'sh7FFF_FFFF;

  localparam logic [63:0] PAIR_RESET [NUM_PAIRS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef enum logic [3:0] {
    S_IDLE, S_XMUL, S_XACC, S_CHECK, S_PDIV, S_PWAIT, S_CMUL, S_CACC,
    S_AREA, S_WDIV, S_WWAIT, S_SMUL, S_SACC, S_UPDATE, S_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_XMUL, OP_XACC, OP_DSTART, OP_DSTORE, OP_CMUL, OP_CACC,
    OP_WSTART, OP_WSTORE, OP_SMUL, OP_SACC, OP_UPDATE, OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] vi;
    logic [1:0] ri;
    logic [1:0] ci;
    logic [2:0] st;
  } cmd_t;

  typedef struct packed {
    logic culled;
    logic area_ok;
    logic div_done;
    logic fin_wait;
  } sts_t;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic [9:0]         mesh_id;
    logic [23:0]        tri_id;
    logic               last_in_pick;
  } item_t;

  typedef struct packed {
    logic               hit_found;
    logic [9:0]         hit_mesh;
    logic [23:0]        hit_triangle;
    logic signed [31:0] hit_depth;
  } res_t;

endpackage

[rtl/ntp_if.sv]
interface ntp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] c_x;
  logic signed [31:0] c_y;
  logic signed [31:0] c_z;
  logic [9:0]         mesh_id;
  logic [23:0]        tri_id;
  logic               last_in_pick;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  mesh_id, tri_id, last_in_pick, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                mesh_id, tri_id, last_in_pick, output ready);
endinterface

interface ntp_out_if;
  logic               valid;
  logic               ready;
  logic               hit_found;
  logic [9:0]         hit_mesh;
  logic [23:0]        hit_triangle;
  logic signed [31:0] hit_depth;

  modport source (output valid, hit_found, hit_mesh, hit_triangle, hit_depth,
                  input ready);
  modport sink (input valid, hit_found, hit_mesh, hit_triangle, hit_depth,
                output ready);
endinterface

[rtl/ntp_div.sv]
module ntp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  input  logic [31:0] cap_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] low_q, low_d;
  logic [31:0] quo_q, quo_d;
  logic [63:0] den_q, den_d;
  logic [31:0] cap_q, cap_d;
  logic [64:0] rem2;
  logic [64:0] diff;
  logic        ovf;

  always_comb begin
    ovf    = {16'd0, num_i} >= {den_i, 16'd0};
    rem2   = {rem_q, low_q[31]};
    diff   = rem2 - {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cap_d  = cap_q;
    if (start_i) begin
      den_d = den_i;
      cap_d = cap_i;
      cnt_d = 5'd0;
      if (ovf) begin
        quo_d  = cap_i;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        rem_d  = {16'd0, num_i[63:16]};
        low_d  = {num_i[15:0], 16'd0};
        quo_d  = 32'd0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_d = diff[63:0];
      end else begin
        rem_d = rem2[63:0];
      end
      low_d = {low_q[30:0], 1'b0};
      quo_d = {quo_q[30:0], ~diff[64]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    den_q <= den_d;
    cap_q <= cap_d;
  end

  assign done_o = done_q;
  assign quo_o  = (quo_q > cap_q) ? cap_q : quo_q;

endmodule

[rtl/ntp_dp.sv]
module ntp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ntp_pkg::cmd_t       cmd_i,
  output ntp_pkg::sts_t       sts_o,
  input  ntp_pkg::item_t      item_i,
  input  logic [63:0]         pairs_i [ntp_pkg::NUM_PAIRS],
  output ntp_pkg::res_t       res_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);

  localparam int HW = ntp_pkg::HW;

  logic signed [31:0]   v_q [3][3];
  logic [9:0]           mesh_q;
  logic [23:0]          tri_q;
  logic                 last_q;
  logic signed [HW-1:0] acc_q;
  logic signed [HW-1:0] hxyz_q [3][3];
  logic signed [HW-1:0] w_q [3];
  logic signed [31:0]   pq_q [3][3];
  logic signed [63:0]   cr_q [4];
  logic [16:0]          wgt_q [3];
  logic signed [HW-1:0] sum_q;
  logic signed [65:0]   prod_q;
  logic                 neg_q;

  logic signed [31:0]   best_q;
  logic [9:0]           bmesh_q;
  logic [23:0]          btri_q;
  logic                 any_q;
  ntp_pkg::res_t        res_q;
  logic                 out_valid_q;

  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   shp;
  logic signed [HW-1:0] acc_d;
  logic signed [HW-1:0] bias;
  logic                 div_start;
  logic [63:0]          div_num, div_den;
  logic [31:0]          div_cap;
  logic                 div_done;
  logic [31:0]          div_quo;
  logic signed [HW-1:0] dn, dd;
  logic signed [63:0]   wo, wt;
  logic signed [63:0]   cr_val;
  logic signed [33:0]   z34;
  logic signed [31:0]   zsat;
  logic [5:0]           m_or, m_and;
  logic [5:0]           m [3];
  logic                 w_zero;
  logic [63:0]          mag_t;
  logic signed [HW:0]   sx, sy, sz;

  function automatic logic signed [31:0] mat_rd(logic [1:0] r, logic [1:0] c,
                                                logic [63:0] p [ntp_pkg::NUM_PAIRS]);
    logic [63:0] pr;
    pr = p[{r, c[1]}];
    return c[0] ? pr[63:32] : pr[31:0];
  endfunction

  function automatic logic signed [32:0] sx33(logic signed [31:0] x);
    return {x[31], x};
  endfunction

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      ntp_pkg::OP_XMUL: begin
        mul_a = sx33(mat_rd(cmd_i.ri, cmd_i.ci, pairs_i));
        mul_b = sx33(v_q[cmd_i.vi][cmd_i.ci]);
      end
      ntp_pkg::OP_CMUL: begin
        case (cmd_i.st)
          3'd0: begin mul_a = sx33(pq_q[2][0]); mul_b = sx33(pq_q[1][1]); end
          3'd1: begin mul_a = sx33(pq_q[1][0]); mul_b = sx33(pq_q[2][1]); end
          3'd2: begin mul_a = sx33(pq_q[0][0]); mul_b = sx33(pq_q[2][1]); end
          3'd3: begin mul_a = sx33(pq_q[2][0]); mul_b = sx33(pq_q[0][1]); end
          3'd4: begin mul_a = sx33(pq_q[1][0]); mul_b = sx33(pq_q[0][1]); end
          3'd5: begin mul_a = sx33(pq_q[0][0]); mul_b = sx33(pq_q[1][1]); end
          3'd6: begin
            mul_a = sx33(pq_q[1][0]) - sx33(pq_q[0][0]);
            mul_b = sx33(pq_q[0][1]) - sx33(pq_q[2][1]);
          end
          default: begin
            mul_a = sx33(pq_q[0][0]) - sx33(pq_q[2][0]);
            mul_b = sx33(pq_q[1][1]) - sx33(pq_q[0][1]);
          end
        endcase
      end
      ntp_pkg::OP_SMUL: begin
        mul_a = {16'd0, wgt_q[cmd_i.vi]};
        mul_b = sx33(pq_q[cmd_i.vi][2]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // transform and cross-product accumulate, divider feed and depth saturation
  always_comb begin
    shp    = prod_q >>> ntp_pkg::FRAC_BITS;
    bias   = HW'(mat_rd(cmd_i.ri, 2'd3, pairs_i));
    acc_d  = ((cmd_i.ci == 2'd0) ? bias : acc_q) + shp[HW-1:0];
    dn     = hxyz_q[cmd_i.vi][cmd_i.ci];
    dd     = w_q[cmd_i.vi];
    wo     = cr_q[cmd_i.vi];
    wt     = cr_q[3];
    cr_val = cmd_i.st[0] ? (cr_q[cmd_i.st[2:1]] - prod_q[63:0]) : prod_q[63:0];
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_cap   = ntp_pkg::ONE_CAP;
    if (cmd_i.op == ntp_pkg::OP_DSTART) begin
      div_start = 1'b1;
      div_num   = 64'(dn[HW-1] ? -dn : dn);
      div_den   = 64'(dd[HW-1] ? -dd : dd);
      div_cap   = (cmd_i.ci == 2'd2) ? ntp_pkg::Q_CAP : ntp_pkg::P_CAP;
    end else if (cmd_i.op == ntp_pkg::OP_WSTART) begin
      div_start = 1'b1;
      div_num   = wo[63] ? -wo : wo;
      div_den   = wt[63] ? -wt : wt;
      div_cap   = ntp_pkg::ONE_CAP;
    end
    z34  = 34'(sum_q >>> ntp_pkg::FRAC_BITS);
    if (z34 > 34'sh0_7FFF_FFFF) begin
      zsat = 32'sh7FFF_FFFF;
    end else if (z34 < -34'sh0_8000_0000) begin
      zsat = 32'sh8000_0000;
    end else begin
      zsat = z34[31:0];
    end
  end

  // plane mask and area checks
  always_comb begin
    m_or   = 6'd0;
    m_and  = 6'h3f;
    w_zero = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sx = {hxyz_q[k][0][HW-1], hxyz_q[k][0]} + {w_q[k][HW-1], w_q[k]};
      sy = {hxyz_q[k][1][HW-1], hxyz_q[k][1]} + {w_q[k][HW-1], w_q[k]};
      sz = {hxyz_q[k][2][HW-1], hxyz_q[k][2]} + {w_q[k][HW-1], w_q[k]};
      m[k] = {hxyz_q[k][0] <= w_q[k], ~sx[HW], hxyz_q[k][1] <= w_q[k], ~sy[HW],
              hxyz_q[k][2] <= w_q[k], ~sz[HW]};
      m_or   = m_or | m[k];
      m_and  = m_and & m[k];
      w_zero = w_zero | (w_q[k] == '0);
    end
    mag_t = cr_q[3][63] ? -cr_q[3] : cr_q[3];
  end

  ntp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .cap_i   (div_cap),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      ntp_pkg::OP_LOAD: begin
        v_q[0][0] <= item_i.a_x;
        v_q[0][1] <= item_i.a_y;
        v_q[0][2] <= item_i.a_z;
        v_q[1][0] <= item_i.b_x;
        v_q[1][1] <= item_i.b_y;
        v_q[1][2] <= item_i.b_z;
        v_q[2][0] <= item_i.c_x;
        v_q[2][1] <= item_i.c_y;
        v_q[2][2] <= item_i.c_z;
        mesh_q    <= item_i.mesh_id;
        tri_q     <= item_i.tri_id;
        last_q    <= item_i.last_in_pick;
      end
      ntp_pkg::OP_XACC: begin
        acc_q <= acc_d;
        if (cmd_i.ci == 2'd2) begin
          if (cmd_i.ri == 2'd3) begin
            w_q[cmd_i.vi] <= acc_d;
          end else begin
            hxyz_q[cmd_i.vi][cmd_i.ri] <= acc_d;
          end
        end
      end
      ntp_pkg::OP_DSTART: begin
        neg_q <= dn[HW-1] ^ dd[HW-1];
      end
      ntp_pkg::OP_DSTORE: begin
        pq_q[cmd_i.vi][cmd_i.ci] <= neg_q ? -div_quo : div_quo;
      end
      ntp_pkg::OP_CACC: begin
        cr_q[cmd_i.st[2:1]] <= cr_val;
      end
      ntp_pkg::OP_WSTORE: begin
        wgt_q[cmd_i.vi] <= div_quo[16:0];
      end
      ntp_pkg::OP_SACC: begin
        sum_q <= ((cmd_i.vi == 2'd0) ? '0 : sum_q) + prod_q[HW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= ntp_pkg::DEPTH_MAX;
      bmesh_q     <= '0;
      btri_q      <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cmd_i.op == ntp_pkg::OP_UPDATE) begin
        if (!any_q || zsat < best_q) begin
          any_q   <= 1'b1;
          best_q  <= zsat;
          bmesh_q <= mesh_q;
          btri_q  <= tri_q;
        end
      end
      if (cmd_i.op == ntp_pkg::OP_FINISH && last_q) begin
        out_valid_q        <= 1'b1;
        res_q.hit_found    <= any_q;
        res_q.hit_mesh     <= any_q ? bmesh_q : '0;
        res_q.hit_triangle <= any_q ? btri_q : '0;
        res_q.hit_depth    <= any_q ? best_q : '0;
        best_q  <= ntp_pkg::DEPTH_MAX;
        bmesh_q <= '0;
        btri_q  <= '0;
        any_q   <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.culled   = (m_or != 6'h3f) | ~m_and[0] | w_zero;
  assign sts_o.area_ok  = (mag_t > ntp_pkg::AREA_EPS) && (cr_q[0][63] == cr_q[3][63]) &&
                          (cr_q[1][63] == cr_q[3][63]) && (cr_q[2][63] == cr_q[3][63]);
  assign sts_o.div_done = div_done;
  assign sts_o.fin_wait = last_q & out_valid_q & ~out_ready_i;
  assign res_o          = res_q;
  assign out_valid_o    = out_valid_q;

endmodule

[rtl/ntp_ctrl.sv]
module ntp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ntp_pkg::sts_t sts_i,
  output ntp_pkg::cmd_t cmd_o
);

  ntp_pkg::state_e state_q, state_d;
  logic [1:0] vi_q, vi_d, ri_q, ri_d, ci_q, ci_d;
  logic [2:0] st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntp_pkg::S_IDLE;
      vi_q    <= '0;
      ri_q    <= '0;
      ci_q    <= '0;
      st_q    <= '0;
    end else begin
      state_q <= state_d;
      vi_q    <= vi_d;
      ri_q    <= ri_d;
      ci_q    <= ci_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    vi_d       = vi_q;
    ri_d       = ri_q;
    ci_d       = ci_q;
    st_d       = st_q;
    in_ready_o = 1'b0;
    cmd_o.op   = ntp_pkg::OP_NONE;
    cmd_o.vi   = vi_q;
    cmd_o.ri   = ri_q;
    cmd_o.ci   = ci_q;
    cmd_o.st   = st_q;
    case (state_q)
      ntp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ntp_pkg::OP_LOAD;
          vi_d     = '0;
          ri_d     = '0;
          ci_d     = '0;
          state_d  = ntp_pkg::S_XMUL;
        end
      end
      ntp_pkg::S_XMUL: begin
        cmd_o.op = ntp_pkg::OP_XMUL;
        state_d  = ntp_pkg::S_XACC;
      end
      ntp_pkg::S_XACC: begin
        cmd_o.op = ntp_pkg::OP_XACC;
        state_d  = ntp_pkg::S_XMUL;
        ci_d     = ci_q + 2'd1;
        if (ci_q == 2'd2) begin
          ci_d = '0;
          ri_d = ri_q + 2'd1;
          if (ri_q == 2'd3) begin
            ri_d = '0;
            vi_d = vi_q + 2'd1;
            if (vi_q == 2'd2) begin
              vi_d    = '0;
              state_d = ntp_pkg::S_CHECK;
            end
          end
        end
      end
      ntp_pkg::S_CHECK: begin
        vi_d    = '0;
        ci_d    = '0;
        state_d = sts_i.culled ? ntp_pkg::S_FIN : ntp_pkg::S_PDIV;
      end
      ntp_pkg::S_PDIV: begin
        cmd_o.op = ntp_pkg::OP_DSTART;
        state_d  = ntp_pkg::S_PWAIT;
      end
      ntp_pkg::S_PWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = ntp_pkg::OP_DSTORE;
          state_d  = ntp_pkg::S_PDIV;
          ci_d     = ci_q + 2'd1;
          if (ci_q == 2'd2) begin
            ci_d = '0;
            vi_d = vi_q + 2'd1;
            if (vi_q == 2'd2) begin
              vi_d    = '0;
              st_d    = '0;
              state_d = ntp_pkg::S_CMUL;
            end
          end
        end
      end
      ntp_pkg::S_CMUL: begin
        cmd_o.op = ntp_pkg::OP_CMUL;
        state_d  = ntp_pkg::S_CACC;
      end
      ntp_pkg::S_CACC: begin
        cmd_o.op = ntp_pkg::OP_CACC;
        st_d     = st_q + 3'd1;
        state_d  = (st_q == 3'd7) ? ntp_pkg::S_AREA : ntp_pkg::S_CMUL;
      end
      ntp_pkg::S_AREA: begin
        vi_d    = '0;
        state_d = sts_i.area_ok ? ntp_pkg::S_WDIV : ntp_pkg::S_FIN;
      end
      ntp_pkg::S_WDIV: begin
        cmd_o.op = ntp_pkg::OP_WSTART;
        state_d  = ntp_pkg::S_WWAIT;
      end
      ntp_pkg::S_WWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = ntp_pkg::OP_WSTORE;
          vi_d     = vi_q + 2'd1;
          state_d  = ntp_pkg::S_WDIV;
          if (vi_q == 2'd2) begin
            vi_d    = '0;
            state_d = ntp_pkg::S_SMUL;
          end
        end
      end
      ntp_pkg::S_SMUL: begin
        cmd_o.op = ntp_pkg::OP_SMUL;
        state_d  = ntp_pkg::S_SACC;
      end
      ntp_pkg::S_SACC: begin
        cmd_o.op = ntp_pkg::OP_SACC;
        vi_d     = vi_q + 2'd1;
        state_d  = ntp_pkg::S_SMUL;
        if (vi_q == 2'd2) begin
          vi_d    = '0;
          state_d = ntp_pkg::S_UPDATE;
        end
      end
      ntp_pkg::S_UPDATE: begin
        cmd_o.op = ntp_pkg::OP_UPDATE;
        state_d  = ntp_pkg::S_FIN;
      end
      ntp_pkg::S_FIN: begin
        if (!sts_i.fin_wait) begin
          cmd_o.op = ntp_pkg::OP_FINISH;
          state_d  = ntp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ntp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/nearest_triangle_pick.sv]
// nearest-depth triangle picker
// in_i takes one world-space triangle per item (three vertices, mesh and
// triangle ids, last flag); out_o gives one result item per pick, after the
// item flagged last has been processed: hit flag, mesh, triangle, depth
// the 4x4 pick matrix sits in eight 64-bit registers on the apb port at
// byte address 8*i; writes take effect at once, reads return the register
// one shared 33x33 multiplier and one radix-2 divider (a divide saturates
// to its cap at once when the quotient overflows) are sequenced per triangle:
// a triangle that reaches the depth test takes 36 transform macs and 12
// divides; one that fails the area or side test skips the weight divides,
// the depth sum and the depth update; one culled after the transform skips
// all divides; the next item is accepted only once the one before is done
// reset loads the identity matrix and clears the best hit
// a stalled out_o holds its item; the next pick keeps running and only
// its own last item waits until the result register is free
module nearest_triangle_pick (
  input  logic        clk_i,
  input  logic        rst_ni,
  ntp_in_if.sink      in_i,
  ntp_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]    pair_q [ntp_pkg::NUM_PAIRS];
  ntp_pkg::cmd_t  cmd;
  ntp_pkg::sts_t  sts;
  ntp_pkg::item_t item;
  ntp_pkg::res_t  res;
  logic           out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= ntp_pkg::PAIR_RESET;
    end else if (psel && penable && pwrite) begin
      pair_q[paddr[5:3]] <= pwdata;
    end
  end

  assign prdata = pair_q[paddr[5:3]];
  assign pready = 1'b1;

  assign item.a_x          = in_i.a_x;
  assign item.a_y          = in_i.a_y;
  assign item.a_z          = in_i.a_z;
  assign item.b_x          = in_i.b_x;
  assign item.b_y          = in_i.b_y;
  assign item.b_z          = in_i.b_z;
  assign item.c_x          = in_i.c_x;
  assign item.c_y          = in_i.c_y;
  assign item.c_z          = in_i.c_z;
  assign item.mesh_id      = in_i.mesh_id;
  assign item.tri_id       = in_i.tri_id;
  assign item.last_in_pick = in_i.last_in_pick;

  ntp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ntp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item),
    .pairs_i     (pair_q),
    .res_o       (res),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready)
  );

  assign out_o.valid        = out_valid;
  assign out_o.hit_found    = res.hit_found;
  assign out_o.hit_mesh     = res.hit_mesh;
  assign out_o.hit_triangle = res.hit_triangle;
  assign out_o.hit_depth    = res.hit_depth;

endmodule
